// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk and rst to be in scope in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define NPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Check that a condition implies a property on the same edge.
`define NPS_ASSERT_IMPL(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition implies a property on the next edge.
`define NPS_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hw/rtl/nps_pkg.sv -----
// Shared types and constants of the priority scheduler.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package nps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ARR_W     = 16;
  localparam int BURST_W   = 16;
  localparam int PRIO_W    = 8;
  localparam int TIME_W    = 21;
  localparam int JOB_IDX_W = 6;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ARR_W-1:0]     arr_t;
  typedef logic [BURST_W-1:0]   burst_t;
  typedef logic [PRIO_W-1:0]    prio_t;
  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [TIME_W:0]      time_sum_t;
  typedef logic [JOB_IDX_W-1:0] job_idx_t;

  localparam time_t TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TURN,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;    // open the job channel
    logic scan;    // examine one stored job
    logic decide;  // advance time after a full pass
    logic turn;    // compute turnaround of the picked job
    logic emit;    // load the result register, retire the job
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic accept;       // job transaction this cycle
    logic sched_start;  // accepted job closes the set
    logic scan_last;    // current scan slot is the last loaded job
    logic found;        // last pass found an arrived job
    logic out_free;     // result register can take a new result
    logic set_done;     // job being retired is the last of the set
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nps_job_if.sv -----
// Job channel: valid/ready handshake with one job descriptor as payload.
// Depends on nps_pkg for field types.
`default_nettype none

interface nps_job_if;
  logic            valid;
  logic            ready;
  nps_pkg::arr_t   arrival_time;
  nps_pkg::burst_t burst_time;
  nps_pkg::prio_t  priority_req;
  logic            last_job;

  modport source (output valid, arrival_time, burst_time, priority_req, last_job,
                  input ready);
  modport sink   (input valid, arrival_time, burst_time, priority_req, last_job,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/nps_result_if.sv -----
// Result channel: valid/ready handshake with one completion record as payload.
// Depends on nps_pkg for field types.
`default_nettype none

interface nps_result_if;
  logic              valid;
  logic              ready;
  nps_pkg::job_idx_t job_index;
  nps_pkg::time_t    completion_time;
  nps_pkg::time_t    turnaround_time;
  nps_pkg::time_t    waiting_time;
  logic              last_result;

  modport source (output valid, job_index, completion_time, turnaround_time,
                  waiting_time, last_result, input ready);
  modport sink   (input valid, job_index, completion_time, turnaround_time,
                  waiting_time, last_result, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/nps_datapath.sv -----
// Scheduler datapath: job stores, scan trackers, time keeping and result register.
// Depends on nps_pkg, nps_job_if, nps_result_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nps_datapath (
  input  wire              clk,
  input  wire              rst,
  nps_job_if.sink          job,
  nps_result_if.source     result,
  input  nps_pkg::cmd_t    cmd,
  output nps_pkg::status_t status
);

  nps_pkg::arr_t   arr_mem   [nps_pkg::MAX_PROCS];
  nps_pkg::burst_t burst_mem [nps_pkg::MAX_PROCS];
  nps_pkg::prio_t  prio_mem  [nps_pkg::MAX_PROCS];
  logic [nps_pkg::MAX_PROCS-1:0] done_flags;

  nps_pkg::time_t cur_time;
  nps_pkg::cnt_t  loaded;
  nps_pkg::cnt_t  completed;
  nps_pkg::idx_t  scan_idx;

  // Best arrived job and earliest pending arrival of the current pass
  logic            found;
  nps_pkg::prio_t  best_prio;
  nps_pkg::idx_t   pick_idx;
  nps_pkg::arr_t   pick_arr;
  nps_pkg::burst_t pick_burst;
  logic            pending;
  nps_pkg::arr_t   earliest;
  nps_pkg::time_t  tat;

  logic              out_valid;
  nps_pkg::job_idx_t res_index;
  nps_pkg::time_t    res_completion;
  nps_pkg::time_t    res_turnaround;
  nps_pkg::time_t    res_waiting;
  logic              res_last;

  logic            accept;
  nps_pkg::idx_t   slot;
  logic            scan_last;
  logic            set_done;
  logic            out_free;
  logic            first;
  logic            found_c;
  nps_pkg::prio_t  best_c;
  logic            pending_c;
  nps_pkg::arr_t   earliest_c;
  logic            e_ready;
  logic            e_wait;
  logic            found_next;
  nps_pkg::prio_t  best_prio_next;
  nps_pkg::idx_t   pick_idx_next;
  nps_pkg::arr_t   pick_arr_next;
  nps_pkg::burst_t pick_burst_next;
  logic            pending_next;
  nps_pkg::arr_t   earliest_next;
  nps_pkg::time_sum_t time_sum;
  nps_pkg::time_t  sat_time;
  nps_pkg::time_t  wait_time;

  assign accept    = job.valid && job.ready;
  assign job.ready = cmd.take;
  assign slot      = loaded[nps_pkg::IDX_W-1:0];
  assign scan_last = (nps_pkg::cnt_t'(scan_idx) + nps_pkg::cnt_t'(1)) == loaded;
  assign set_done  = (completed + nps_pkg::cnt_t'(1)) == loaded;
  assign out_free  = !out_valid || result.ready;

  assign status.accept      = accept;
  assign status.sched_start = job.last_job ||
                              ((loaded + nps_pkg::cnt_t'(1)) ==
                               nps_pkg::cnt_t'(nps_pkg::MAX_PROCS));
  assign status.scan_last   = scan_last;
  assign status.found       = found;
  assign status.out_free    = out_free;
  assign status.set_done    = set_done;

  // One stored job per cycle; trackers restart at slot zero
  always_comb begin
    first      = (scan_idx == '0);
    found_c    = first ? 1'b0 : found;
    best_c     = best_prio;
    pending_c  = first ? 1'b0 : pending;
    earliest_c = earliest;
    e_ready    = !done_flags[scan_idx] &&
                 (nps_pkg::time_t'(arr_mem[scan_idx]) <= cur_time);
    e_wait     = !done_flags[scan_idx] &&
                 (nps_pkg::time_t'(arr_mem[scan_idx]) > cur_time);

    found_next      = found_c;
    best_prio_next  = best_c;
    pick_idx_next   = pick_idx;
    pick_arr_next   = pick_arr;
    pick_burst_next = pick_burst;
    pending_next    = pending_c;
    earliest_next   = earliest_c;

    if (e_ready && (!found_c || (prio_mem[scan_idx] < best_c))) begin
      found_next      = 1'b1;
      best_prio_next  = prio_mem[scan_idx];
      pick_idx_next   = scan_idx;
      pick_arr_next   = arr_mem[scan_idx];
      pick_burst_next = burst_mem[scan_idx];
    end
    if (e_wait && (!pending_c || (arr_mem[scan_idx] < earliest_c))) begin
      pending_next  = 1'b1;
      earliest_next = arr_mem[scan_idx];
    end
  end

  always_comb begin
    time_sum  = nps_pkg::time_sum_t'(cur_time) + nps_pkg::time_sum_t'(pick_burst);
    sat_time  = time_sum[nps_pkg::TIME_W] ? nps_pkg::TIME_MAX
                                           : time_sum[nps_pkg::TIME_W-1:0];
    wait_time = (tat >= nps_pkg::time_t'(pick_burst))
                ? tat - nps_pkg::time_t'(pick_burst) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_flags <= '0;
      cur_time   <= '0;
      loaded     <= '0;
      completed  <= '0;
      scan_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        done_flags[slot] <= 1'b0;
        loaded           <= loaded + nps_pkg::cnt_t'(1);
      end
      if (cmd.scan) begin
        scan_idx <= scan_last ? '0 : scan_idx + nps_pkg::idx_t'(1);
      end
      // Add the burst (saturating), else jump to the earliest pending arrival
      if (cmd.decide) begin
        cur_time <= found ? sat_time : nps_pkg::time_t'(earliest);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (set_done) begin
          done_flags <= '0;
          cur_time   <= '0;
          loaded     <= '0;
          completed  <= '0;
        end else begin
          done_flags[pick_idx] <= 1'b1;
          completed            <= completed + nps_pkg::cnt_t'(1);
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arr_mem[slot]   <= job.arrival_time;
      burst_mem[slot] <= job.burst_time;
      prio_mem[slot]  <= job.priority_req;
    end
    if (cmd.scan) begin
      found      <= found_next;
      best_prio  <= best_prio_next;
      pick_idx   <= pick_idx_next;
      pick_arr   <= pick_arr_next;
      pick_burst <= pick_burst_next;
      pending    <= pending_next;
      earliest   <= earliest_next;
    end
    if (cmd.turn) begin
      tat <= cur_time - nps_pkg::time_t'(pick_arr);
    end
    if (cmd.emit) begin
      res_index      <= nps_pkg::job_idx_t'(pick_idx);
      res_completion <= cur_time;
      res_turnaround <= tat;
      res_waiting    <= wait_time;
      res_last       <= set_done;
    end
  end

  assign result.valid           = out_valid;
  assign result.job_index       = res_index;
  assign result.completion_time = res_completion;
  assign result.turnaround_time = res_turnaround;
  assign result.waiting_time    = res_waiting;
  assign result.last_result     = res_last;

  `NPS_ASSERT(a_completed_le_loaded, completed <= loaded, "more jobs retired than loaded")
  `NPS_ASSERT_NEXT(a_emit_index_loaded, cmd.emit && !set_done,
                   res_index < nps_pkg::job_idx_t'($past(loaded)),
                   "emitted job index beyond loaded jobs")
  `NPS_ASSERT_IMPL(a_decide_has_candidate, cmd.decide, found || pending,
                   "scan pass ended with no open job")

endmodule

`default_nettype wire

// ----- hw/rtl/nps_ctrl.sv -----
// Scheduler controller: sequences loading, scan passes, completion and emission.
// Depends on nps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nps_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  nps_pkg::status_t status,
  output nps_pkg::cmd_t    cmd
);

  nps_pkg::state_t state;
  nps_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      nps_pkg::ST_IDLE: begin
        cmd.take = 1'b1;
        if (status.accept && status.sched_start) begin
          state_next = nps_pkg::ST_SCAN;
        end
      end
      nps_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = nps_pkg::ST_DECIDE;
        end
      end
      nps_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.found ? nps_pkg::ST_TURN : nps_pkg::ST_SCAN;
      end
      nps_pkg::ST_TURN: begin
        cmd.turn   = 1'b1;
        state_next = nps_pkg::ST_EMIT;
      end
      nps_pkg::ST_EMIT: begin
        // Hold until the result register drains
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.set_done ? nps_pkg::ST_IDLE : nps_pkg::ST_SCAN;
        end
      end
      default: begin
        state_next = nps_pkg::ST_IDLE;
      end
    endcase
  end

  `NPS_ASSERT_IMPL(a_emit_needs_room, cmd.emit, status.out_free,
                   "result loaded while register still full")
  `NPS_ASSERT_NEXT(a_set_end_idle, cmd.emit && status.set_done,
                   state == nps_pkg::ST_IDLE, "set finished but loading not reopened")
  `NPS_ASSERT_NEXT(a_start_scans, status.accept && status.sched_start,
                   cmd.scan && !cmd.take, "closing job did not start a scan")

endmodule

`default_nettype wire

// ----- hw/rtl/nonpreemptive_priority_scheduler.sv -----
// Non-preemptive priority scheduler, top level.
// Depends on nps_pkg, nps_job_if, nps_result_if, nps_ctrl and nps_datapath.
//
// Usage: jobs arrive on the job channel, one transaction per cycle while the
// block is loading. A job with last_job set, or the one that fills all
// MAX_PROCS slots, closes the set; job.ready then drops until the schedule
// has run. Starting at time 0 the block repeatedly picks the arrived, unfinished
// job with the lowest priority number (ties to the lowest index) and runs it to
// completion; one record per job leaves on the result channel in completion
// order, last_result marking the final one.
// Each decision point costs one scan pass over the jobs in the set (one stored
// job examined per cycle) plus a decide step. A pass that finds nothing arrived
// jumps time to the earliest arrival and scans again; a pass that picks a job
// goes through the turn and emit states before the record is loaded.
// The result register holds its record while result.ready is low and the
// controller waits; after the last record is loaded, new jobs are accepted
// even while that record is still waiting to be taken.
// Reset (synchronous rst): empty set, time 0, no result pending.
`default_nettype none

module nonpreemptive_priority_scheduler (
  input  wire          clk,
  input  wire          rst,
  nps_job_if.sink      job,
  nps_result_if.source result
);

  nps_pkg::cmd_t    cmd;
  nps_pkg::status_t status;

  nps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  nps_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .job    (job),
    .result (result),
    .cmd    (cmd),
    .status (status)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for the non-preemptive priority scheduler: job sets in,
// completion records out, checked against a behavioral schedule kept here.
// Depends on nps_pkg, nps_job_if, nps_result_if and the scheduler top level.

module tb_top;

  typedef struct packed {
    nps_pkg::arr_t   arrival;
    nps_pkg::burst_t burst;
    nps_pkg::prio_t  prio;
    logic            last;
  } job_rec_t;

  typedef struct packed {
    nps_pkg::job_idx_t idx;
    nps_pkg::time_t    finish_at;
    nps_pkg::time_t    turnaround;
    nps_pkg::time_t    waiting;
    logic              last;
  } completion_t;

  logic clk = 1'b0;
  logic rst;

  nps_job_if    job_ch ();
  nps_result_if result_ch ();

  nonpreemptive_priority_scheduler dut (
    .clk    (clk),
    .rst    (rst),
    .job    (job_ch),
    .result (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  job_rec_t    pending_jobs[$];
  completion_t expected_completions[$];
  job_rec_t    cur_job;
  completion_t seen_rec;
  completion_t want_rec;
  int unsigned jobs_accepted  = 0;
  int unsigned mismatch_count = 0;

  // Scheduler state as the block should hold it
  nps_pkg::arr_t   held_arrival[nps_pkg::MAX_PROCS];
  nps_pkg::burst_t held_burst[nps_pkg::MAX_PROCS];
  nps_pkg::prio_t  held_prio[nps_pkg::MAX_PROCS];
  bit              held_done[nps_pkg::MAX_PROCS];
  int unsigned     jobs_held = 0;

  // Store one job; when it closes the set, play out the whole schedule
  task automatic predict_completions(input job_rec_t j);
    int unsigned n, finished, now, pick, best, earliest, tat, wt;
    bit          found, pending;
    completion_t c;
    held_arrival[jobs_held] = j.arrival;
    held_burst[jobs_held]   = j.burst;
    held_prio[jobs_held]    = j.prio;
    held_done[jobs_held]    = 1'b0;
    jobs_held++;
    if (j.last || jobs_held == nps_pkg::MAX_PROCS) begin
      n        = jobs_held;
      now      = 0;
      finished = 0;
      while (finished < n) begin
        found    = 1'b0;
        pending  = 1'b0;
        pick     = 0;
        best     = 0;
        earliest = 0;
        for (int k = 0; k < n; k++) begin
          if (!held_done[k]) begin
            if (held_arrival[k] <= now) begin
              if (!found || held_prio[k] < best) begin
                found = 1'b1;
                best  = held_prio[k];
                pick  = k;
              end
            end else if (!pending || held_arrival[k] < earliest) begin
              pending  = 1'b1;
              earliest = held_arrival[k];
            end
          end
        end
        if (!found) begin
          // nothing ready: jump to the earliest arrival
          now = earliest;
        end else begin
          now = now + held_burst[pick];
          if (now > nps_pkg::TIME_MAX) now = nps_pkg::TIME_MAX;
          tat = now - held_arrival[pick];
          wt  = (tat >= held_burst[pick]) ? tat - held_burst[pick] : 0;
          held_done[pick] = 1'b1;
          finished++;
          c.idx        = nps_pkg::job_idx_t'(pick);
          c.finish_at  = nps_pkg::time_t'(now);
          c.turnaround = nps_pkg::time_t'(tat);
          c.waiting    = nps_pkg::time_t'(wt);
          c.last       = (finished == n);
          expected_completions.push_back(c);
        end
      end
      jobs_held = 0;
      for (int k = 0; k < nps_pkg::MAX_PROCS; k++) held_done[k] = 1'b0;
    end
  endtask

  function automatic job_rec_t random_job(input bit close);
    job_rec_t j;
    case ($urandom_range(3))
      0, 1:    j.arrival = nps_pkg::arr_t'($urandom_range(40));
      2:       j.arrival = nps_pkg::arr_t'($urandom);
      default: j.arrival = '0;
    endcase
    case ($urandom_range(9))
      0:       j.burst = '0;
      1, 2, 3: j.burst = nps_pkg::burst_t'($urandom);
      default: j.burst = nps_pkg::burst_t'($urandom_range(20));
    endcase
    // narrow priorities often, so ties get exercised
    j.prio = $urandom_range(1) ? nps_pkg::prio_t'($urandom_range(3))
                               : nps_pkg::prio_t'($urandom);
    j.last = close;
    return j;
  endfunction

  function automatic int unsigned sender_idle_pct();
    if (jobs_accepted < 110) return 23;
    if (jobs_accepted < 220) return 72;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (jobs_accepted < 110) return 72;
    if (jobs_accepted < 220) return 23;
    return 0;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Job driver: hold each transaction until it is taken
  always @(posedge clk) begin
    if (rst) begin
      job_ch.valid        <= 1'b0;
      job_ch.arrival_time <= '0;
      job_ch.burst_time   <= '0;
      job_ch.priority_req <= '0;
      job_ch.last_job     <= 1'b0;
    end else begin
      if (job_ch.valid && job_ch.ready) begin
        predict_completions(cur_job);
        jobs_accepted++;
      end
      if (!job_ch.valid || job_ch.ready) begin
        if (pending_jobs.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          cur_job = pending_jobs.pop_front();
          job_ch.valid        <= 1'b1;
          job_ch.arrival_time <= cur_job.arrival;
          job_ch.burst_time   <= cur_job.burst;
          job_ch.priority_req <= cur_job.prio;
          job_ch.last_job     <= cur_job.last;
        end else begin
          job_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        seen_rec = '{result_ch.job_index, result_ch.completion_time,
                     result_ch.turnaround_time, result_ch.waiting_time,
                     result_ch.last_result};
        if (expected_completions.size() == 0) begin
          $display("%0t: unexpected completion: expected none, actual job %0d at %0d",
                   $time, seen_rec.idx, seen_rec.finish_at);
          mismatch_count++;
        end else begin
          want_rec = expected_completions.pop_front();
          check_field("job_index", want_rec.idx, seen_rec.idx);
          check_field("completion_time", want_rec.finish_at, seen_rec.finish_at);
          check_field("turnaround_time", want_rec.turnaround, seen_rec.turnaround);
          check_field("waiting_time", want_rec.waiting, seen_rec.waiting);
          check_field("last_result", want_rec.last, seen_rec.last);
        end
      end
      result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  initial begin
    int unsigned set_size;
    rst = 1'b1;

    // Single jobs: zero burst at time 0, then all fields at their maximum
    pending_jobs.push_back(job_rec_t'{16'd0, 16'd0, 8'd0, 1'b1});
    pending_jobs.push_back(job_rec_t'{16'hFFFF, 16'hFFFF, 8'hFF, 1'b1});
    // Three jobs with equal and differing priorities, loaded out of arrival order
    pending_jobs.push_back(job_rec_t'{16'd5, 16'd3, 8'd7, 1'b0});
    pending_jobs.push_back(job_rec_t'{16'd0, 16'd4, 8'd7, 1'b0});
    pending_jobs.push_back(job_rec_t'{16'd1, 16'd2, 8'd2, 1'b1});
    // Idle stretches before and between jobs
    pending_jobs.push_back(job_rec_t'{16'd100, 16'd5, 8'd0, 1'b0});
    pending_jobs.push_back(job_rec_t'{16'd10, 16'd5, 8'd9, 1'b1});
    // Full store with last_job never set
    for (int k = 0; k < nps_pkg::MAX_PROCS; k++)
      pending_jobs.push_back(job_rec_t'{nps_pkg::arr_t'(3 * k), nps_pkg::burst_t'(k),
                                        nps_pkg::prio_t'((15 - k) % 4), 1'b0});

    while (pending_jobs.size() < 310) begin
      set_size = ($urandom_range(7) == 0) ? nps_pkg::MAX_PROCS : $urandom_range(1, 8);
      for (int k = 0; k < set_size; k++)
        pending_jobs.push_back(random_job(k == set_size - 1 &&
                                          (set_size < nps_pkg::MAX_PROCS ||
                                           $urandom_range(1))));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_jobs.size() != 0 || job_ch.valid || expected_completions.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
